// ----- rtl/core/http_chunked_body_decoder_assert.svh -----
// Assertion macros shared by the chunked body decoder RTL.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/hcbd_pkg.sv -----
// Types, constants and helper functions for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

    localparam int SIZE_WIDTH = 32;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_SIZE_LF = 3'd1,
        PH_DATA    = 3'd2,
        PH_DATA_CR = 3'd3,
        PH_DATA_LF = 3'd4,
        PH_LAST_CR = 3'd5,
        PH_LAST_LF = 3'd6,
        PH_DONE    = 3'd7
    } phase_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       message_start;
    } in_word_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       chunk_last;
        logic       message_complete;
        logic       size_overflow;
    } out_word_t;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b0;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            h.is_hex = 1'b1;
            h.value  = 4'(c - 8'h37);
        end
        return h;
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hcbd_parser.sv -----
// Chunk framing state and the combinational next-state update for one body byte.
`default_nettype none

module hcbd_parser (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic step,
    input  wire  hcbd_pkg::in_word_t  word,
    output hcbd_pkg::out_word_t       result
);
    import hcbd_pkg::*;

    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = {SIZE_WIDTH{1'b1}};

    phase_t                phase_reg, phase_next;
    logic [SIZE_WIDTH-1:0] accum_reg, accum_next;
    logic [SIZE_WIDTH-1:0] remain_reg, remain_next;
    logic                  stopped_reg, stopped_next;
    logic [1:0]            digits_reg, digits_next;
    logic                  complete_reg, complete_next;
    logic                  overflow_reg, overflow_next;

    phase_t                phase_b;
    logic [SIZE_WIDTH-1:0] accum_b;
    logic [SIZE_WIDTH-1:0] remain_b;
    logic                  stopped_b;
    logic [1:0]            digits_b;
    logic                  complete_b;
    logic                  overflow_b;
    logic [7:0]            c;
    hex_t                  hex;
    logic [SIZE_WIDTH-1:0] remain_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SIZE;
            accum_reg    <= '0;
            remain_reg   <= '0;
            stopped_reg  <= 1'b0;
            digits_reg   <= 2'd0;
            complete_reg <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg    <= phase_next;
            accum_reg    <= accum_next;
            remain_reg   <= remain_next;
            stopped_reg  <= stopped_next;
            digits_reg   <= digits_next;
            complete_reg <= complete_next;
            overflow_reg <= overflow_next;
        end
    end

    always_comb
    begin
        c   = word.body_byte;
        hex = hex_decode(c);

        // A message start puts every field back to its reset value first.
        if (word.message_start)
        begin
            phase_b    = PH_SIZE;
            accum_b    = '0;
            remain_b   = '0;
            stopped_b  = 1'b0;
            digits_b   = 2'd0;
            complete_b = 1'b0;
            overflow_b = 1'b0;
        end
        else
        begin
            phase_b    = phase_reg;
            accum_b    = accum_reg;
            remain_b   = remain_reg;
            stopped_b  = stopped_reg;
            digits_b   = digits_reg;
            complete_b = complete_reg;
            overflow_b = overflow_reg;
        end

        phase_next    = phase_b;
        accum_next    = accum_b;
        remain_next   = remain_b;
        stopped_next  = stopped_b;
        digits_next   = digits_b;
        complete_next = complete_b;
        overflow_next = overflow_b;
        remain_dec    = remain_b - SIZE_WIDTH'(1);

        result.payload_byte  = 8'd0;
        result.payload_valid = 1'b0;
        result.chunk_last    = 1'b0;

        unique case (phase_b)
            PH_SIZE:
            begin
                if (is_alnum(c))
                begin
                    if (!stopped_b)
                    begin
                        if (hex.is_hex)
                        begin
                            if (|accum_b[SIZE_WIDTH-1 -: 4])
                            begin
                                accum_next    = SIZE_MAX;
                                overflow_next = 1'b1;
                            end
                            else
                            begin
                                accum_next = {accum_b[SIZE_WIDTH-5:0], hex.value};
                            end
                            if (digits_b != 2'd2)
                                digits_next = digits_b + 2'd1;
                        end
                        else if ((c == 8'h78 || c == 8'h58) && digits_b == 2'd1 &&
                                 accum_b == '0)
                        begin
                            digits_next = 2'd2;
                        end
                        else
                        begin
                            stopped_next = 1'b1;
                        end
                    end
                end
                else if (c == CH_CR)
                begin
                    phase_next = PH_SIZE_LF;
                end
            end
            PH_SIZE_LF:
            begin
                if (c == CH_LF)
                begin
                    remain_next  = accum_b;
                    accum_next   = '0;
                    digits_next  = 2'd0;
                    stopped_next = 1'b0;
                    phase_next   = (accum_b == '0) ? PH_LAST_CR : PH_DATA;
                end
            end
            PH_DATA:
            begin
                result.payload_byte  = c;
                result.payload_valid = 1'b1;
                remain_next          = remain_dec;
                if (remain_dec == '0)
                begin
                    result.chunk_last = 1'b1;
                    phase_next        = PH_DATA_CR;
                end
            end
            PH_DATA_CR:
            begin
                if (c == CH_CR)
                    phase_next = PH_DATA_LF;
            end
            PH_DATA_LF:
            begin
                if (c == CH_LF)
                    phase_next = PH_SIZE;
            end
            PH_LAST_CR:
            begin
                if (c == CH_CR)
                    phase_next = PH_LAST_LF;
            end
            PH_LAST_LF:
            begin
                if (c == CH_LF)
                begin
                    complete_next = 1'b1;
                    phase_next    = PH_DONE;
                end
            end
            PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        result.message_complete = complete_next;
        result.size_overflow    = overflow_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/http_chunked_body_decoder.sv -----
// Top level of the chunked body decoder: input register, parser and result register.
//
//  Channel   Handshake                  Word
//  input     byte_valid / byte_stall    byte_data   (body_byte, message_start)
//  result    result_valid / result_stall result_data (payload and status flags)
//
// One byte is accepted per cycle while byte_stall is low; each byte gives one result
// word via the input and result registers. The parser state updates as a byte moves
// between them, so the throughput is one word per cycle when neither side stalls.
// Reset returns the parser to size collection with all counts and flags cleared.
// A stalled result holds; the input register fills behind it, then byte_stall rises.
`default_nettype none

module http_chunked_body_decoder (
    input  wire                       logic clk,
    input  wire                       logic rst_n,
    input  wire                       logic byte_valid,
    output logic                      byte_stall,
    input  wire  hcbd_pkg::in_word_t  byte_data,
    output logic                      result_valid,
    input  wire                       logic result_stall,
    output hcbd_pkg::out_word_t       result_data
);
    import hcbd_pkg::*;

`include "http_chunked_body_decoder_assert.svh"

    logic      hold_valid_reg, hold_valid_next;
    in_word_t  hold_word_reg;
    logic      result_valid_reg, result_valid_next;
    out_word_t result_word_reg;
    out_word_t step_result;
    logic      take_in;
    logic      out_free;
    logic      step;

    assign out_free   = !result_valid_reg || !result_stall;
    assign step       = hold_valid_reg && out_free;
    assign byte_stall = hold_valid_reg && !out_free;
    assign take_in    = byte_valid && !byte_stall;

    assign result_valid = result_valid_reg;
    assign result_data  = result_word_reg;

    hcbd_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (hold_word_reg),
        .result (step_result)
    );

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take_in)
            hold_valid_next = 1'b1;
        else if (step)
            hold_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (step)
            result_valid_next = 1'b1;
        else if (out_free)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
            hold_word_reg <= byte_data;
        if (step)
            result_word_reg <= step_result;
    end

    `HCBD_ASSERT_SAME(a_idle_byte_zero, clk, rst_n,
        result_valid_reg && !result_word_reg.payload_valid,
        result_word_reg.payload_byte == 8'd0, "non-payload word carries a byte")
    `HCBD_ASSERT_SAME(a_last_is_payload, clk, rst_n,
        result_valid_reg && result_word_reg.chunk_last,
        result_word_reg.payload_valid, "chunk end marked on a non-payload word")
    `HCBD_ASSERT_SAME(a_no_payload_after_end, clk, rst_n,
        result_valid_reg && result_word_reg.message_complete,
        !result_word_reg.payload_valid, "payload after message completion")
    `HCBD_ASSERT_NEXT(a_stalled_result_kept, clk, rst_n,
        result_valid_reg && result_stall,
        result_valid_reg && $stable(result_word_reg), "stalled result word lost")

endmodule

`default_nettype wire

// ----- tb/http_chunked_body_decoder_tb.sv -----
// Self-checking testbench for the chunked body decoder: random framed messages, noise and stalls.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder_tb;

    import hcbd_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DIRECTED_BYTES = 30;
    localparam int RANDOM_BYTES = 920;
    localparam logic [SIZE_WIDTH-1:0] SIZE_MAX = {SIZE_WIDTH{1'b1}};

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      byte_valid = 1'b0;
    logic      byte_stall;
    in_word_t  byte_data = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_word_t result_data;

    in_word_t  pending_words[$];
    out_word_t expected_words[$];
    out_word_t exp_word;
    logic      in_taken = 1'b0;
    logic      start_next = 1'b0;
    logic      calm;
    int        items_accepted = 0;
    int        results_seen = 0;
    int        error_count = 0;
    int        cycle_count = 0;
    int        n_messages = 0;
    int        n_payload = 0;
    int        n_complete = 0;
    int        n_oversize = 0;

    phase_t                cur_phase;
    logic [SIZE_WIDTH-1:0] size_acc;
    logic [SIZE_WIDTH-1:0] count_left;
    logic                  size_ended;
    logic [1:0]            digit_seen;
    logic                  msg_done;
    logic                  size_sat;

    http_chunked_body_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    assign calm = (items_accepted >= 350) && (items_accepted < 550);

    function automatic void clear_parser();
        cur_phase  = PH_SIZE;
        size_acc   = '0;
        count_left = '0;
        size_ended = 1'b0;
        digit_seen = 2'd0;
        msg_done   = 1'b0;
        size_sat   = 1'b0;
    endfunction

    function automatic out_word_t decode_byte(in_word_t w);
        out_word_t  r;
        logic [7:0] c;
        int         v;
        r = '0;
        c = w.body_byte;
        if (w.message_start)
            clear_parser();
        case (cur_phase)
            PH_SIZE:
            begin
                if ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"))
                begin
                    if (!size_ended)
                    begin
                        v = -1;
                        if (c >= "0" && c <= "9")
                            v = c - "0";
                        else if (c >= "a" && c <= "f")
                            v = c - "a" + 10;
                        else if (c >= "A" && c <= "F")
                            v = c - "A" + 10;
                        if (v >= 0)
                        begin
                            if (size_acc > (SIZE_MAX >> 4))
                            begin
                                if (!size_sat)
                                    n_oversize++;
                                size_acc = SIZE_MAX;
                                size_sat = 1'b1;
                            end
                            else
                                size_acc = {size_acc[SIZE_WIDTH-5:0], 4'(v)};
                            if (digit_seen < 2'd2)
                                digit_seen = digit_seen + 2'd1;
                        end
                        else if ((c == "x" || c == "X") && digit_seen == 2'd1 && size_acc == '0)
                            digit_seen = 2'd2;
                        else
                            size_ended = 1'b1;
                    end
                end
                else if (c == CH_CR)
                    cur_phase = PH_SIZE_LF;
            end
            PH_SIZE_LF:
            begin
                if (c == CH_LF)
                begin
                    count_left = size_acc;
                    size_acc   = '0;
                    digit_seen = 2'd0;
                    size_ended = 1'b0;
                    cur_phase  = (count_left == '0) ? PH_LAST_CR : PH_DATA;
                end
            end
            PH_DATA:
            begin
                r.payload_byte  = c;
                r.payload_valid = 1'b1;
                count_left = count_left - SIZE_WIDTH'(1);
                if (count_left == '0)
                begin
                    r.chunk_last = 1'b1;
                    cur_phase = PH_DATA_CR;
                end
            end
            PH_DATA_CR:
                if (c == CH_CR)
                    cur_phase = PH_DATA_LF;
            PH_DATA_LF:
                if (c == CH_LF)
                    cur_phase = PH_SIZE;
            PH_LAST_CR:
                if (c == CH_CR)
                    cur_phase = PH_LAST_LF;
            PH_LAST_LF:
            begin
                if (c == CH_LF)
                begin
                    msg_done = 1'b1;
                    n_complete++;
                    cur_phase = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
        r.message_complete = msg_done;
        r.size_overflow    = size_sat;
        return r;
    endfunction

    task automatic push_byte(logic [7:0] b);
        in_word_t w;
        w.body_byte     = b;
        w.message_start = start_next;
        start_next = 1'b0;
        pending_words.push_back(w);
    endtask

    function automatic logic [7:0] hex_char(int v);
        if (v < 10)
            return 8'("0" + v);
        return 8'(($urandom_range(1) ? "A" : "a") + v - 10);
    endfunction

    task automatic push_size(int unsigned value);
        int nd;
        int r;
        int i;
        nd = 1;
        while (nd < 8 && (value >> (4 * nd)) != 0)
            nd++;
        r = $urandom_range(9);
        if (r < 2)
        begin
            push_byte("0");
            push_byte((r == 0) ? "X" : "x");
        end
        else if (r == 2)
            push_byte("0");
        for (i = nd - 1; i >= 0; i--)
            push_byte(hex_char((value >> (4 * i)) & 15));
    endtask

    task automatic push_extension();
        int n;
        int r;
        push_byte(";");
        push_byte(8'(($urandom_range(1) ? "G" : "g") + $urandom_range(19)));
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            r = $urandom_range(63);
            if (r < 10)
                push_byte(8'("0" + r));
            else if (r < 36)
                push_byte(8'("a" + r - 10));
            else if (r < 62)
                push_byte(8'("A" + r - 36));
            else
                push_byte("=");
        end
    endtask

    task automatic gen_message();
        int kind;
        int n_chunks;
        int len;
        int i;
        int k;
        int r;
        kind = $urandom_range(99);
        n_messages++;
        if (kind < 10)
        begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++)
            begin
                start_next = ($urandom_range(5) == 0);
                r = $urandom_range(3);
                if (r < 2)
                    push_byte(8'($urandom_range(255)));
                else if (r == 2)
                    push_byte($urandom_range(1) ? CH_CR : CH_LF);
                else
                    push_byte(hex_char($urandom_range(15)));
            end
            return;
        end
        start_next = 1'b1;
        n_chunks = $urandom_range(0, 3);
        for (k = 0; k < n_chunks; k++)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 6);
            push_size(len);
            if ($urandom_range(6) == 0)
                push_extension();
            push_byte(CH_CR);
            if ($urandom_range(9) == 0)
                push_byte(8'($urandom_range(255)));
            push_byte(CH_LF);
            for (i = 0; i < len; i++)
                push_byte(8'($urandom_range(255)));
            if ($urandom_range(9) == 0)
                push_byte(8'($urandom_range(255)));
            push_byte(CH_CR);
            push_byte(CH_LF);
            if ($urandom_range(19) == 0)
                return;
        end
        if (kind < 16)
        begin
            push_byte(hex_char($urandom_range(1, 15)));
            len = $urandom_range(8, 9);
            for (i = 0; i < len; i++)
                push_byte(hex_char($urandom_range(15)));
            push_byte(CH_CR);
            push_byte(CH_LF);
            len = $urandom_range(1, 5);
            for (i = 0; i < len; i++)
                push_byte(8'($urandom_range(255)));
            return;
        end
        push_size(0);
        if ($urandom_range(7) == 0)
            push_extension();
        push_byte(CH_CR);
        push_byte(CH_LF);
        if ($urandom_range(4) == 0)
            push_byte(8'($urandom_range(255)));
        push_byte(CH_CR);
        push_byte(CH_LF);
        if ($urandom_range(3) == 0)
        begin
            len = $urandom_range(1, 4);
            for (i = 0; i < len; i++)
                push_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("Mismatch on result %0d: %s, got %0h, expected %0h.",
                 results_seen, what, got, want);
        error_count++;
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || in_taken))
        begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 31))
            begin
                byte_data  <= pending_words.pop_front();
                byte_valid <= 1'b1;
            end
            else
                byte_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            result_stall <= calm ? 1'b0 : ($urandom_range(99) < 31);
    end

    always @(posedge clk)
    begin
        in_taken <= rst_n && byte_valid && !byte_stall;
        if (rst_n && byte_valid && !byte_stall)
        begin
            exp_word = decode_byte(byte_data);
            if (exp_word.payload_valid)
                n_payload++;
            expected_words.push_back(exp_word);
            items_accepted++;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("result word with none expected", result_data, 0);
            else
            begin
                exp_word = expected_words.pop_front();
                if (result_data.payload_byte !== exp_word.payload_byte)
                    report_mismatch("payload_byte", result_data.payload_byte,
                                    exp_word.payload_byte);
                if (result_data.payload_valid !== exp_word.payload_valid)
                    report_mismatch("payload_valid", result_data.payload_valid,
                                    exp_word.payload_valid);
                if (result_data.chunk_last !== exp_word.chunk_last)
                    report_mismatch("chunk_last", result_data.chunk_last,
                                    exp_word.chunk_last);
                if (result_data.message_complete !== exp_word.message_complete)
                    report_mismatch("message_complete", result_data.message_complete,
                                    exp_word.message_complete);
                if (result_data.size_overflow !== exp_word.size_overflow)
                    report_mismatch("size_overflow", result_data.size_overflow,
                                    exp_word.size_overflow);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Timed out with %0d words still expected.", expected_words.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        clear_parser();

        // An oversize size that saturates, ended by a non-hex letter; a later letter is ignored.
        start_next = 1'b1;
        n_messages++;
        repeat (9)
            push_byte("F");
        push_byte("k");
        push_byte("x");

        // A 0X prefix, ignored punctuation, stray bytes while waiting, extreme payload values.
        start_next = 1'b1;
        n_messages++;
        push_byte("0");
        push_byte("X");
        push_byte("2");
        push_byte(";");
        push_byte(CH_CR);
        push_byte("Z");
        push_byte(CH_LF);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte("q");
        push_byte(CH_CR);
        push_byte(CH_LF);

        // The closing zero chunk with a stray byte, then a byte after completion.
        push_byte("0");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte("7");
        push_byte(CH_CR);
        push_byte(CH_LF);
        push_byte(8'h80);

        while (pending_words.size() < DIRECTED_BYTES + RANDOM_BYTES)
            gen_message();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || byte_valid)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Checked %0d result words from %0d messages, framed and noisy.",
                 results_seen, n_messages);
        $display("They carried %0d payload bytes, %0d completions and %0d saturated sizes.",
                 n_payload, n_complete, n_oversize);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
